// ----- rtl/imep_pkg.sv -----
// Shared types, constants and the byte classifier of the indented markup event parser.
// Used by the front, queue, back and top-level modules. Depends on nothing else.
`timescale 1ns / 1ps
package imep_pkg;

	localparam int NEST_DEPTH  = 16;
	localparam int POS_BITS    = 16;
	localparam int INDENT_BITS = 8;
	localparam int LVL_BITS    = $clog2(NEST_DEPTH);
	localparam int DEPTH_BITS  = $clog2(NEST_DEPTH + 1);
	localparam int EV_CAP      = NEST_DEPTH + 4;
	localparam int CNT_BITS    = $clog2(EV_CAP + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h00;

	typedef enum logic [2:0] {
		EV_NODE, EV_END, EV_BADNAME, EV_DEEP, EV_INDENT, EV_UNESC, EV_ILLEGAL, EV_EOF
	} kind_t;

	typedef enum logic [1:0] {VF_NONE, VF_QUOTED, VF_PLAIN, VF_COLON} form_t;

	typedef enum logic [1:0] {MODE_CHILD, MODE_ATTR, MODE_INDENT, MODE_DONE} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_NAME, PH_EQ, PH_QUOTED, PH_PLAIN, PH_PLAIN_CR, PH_COLON
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_RUN, BK_ATTR_END, BK_POP, BK_CLOSE, BK_EOF, BK_FLUSH
	} bk_state_t;

	typedef struct packed {
		logic is_name;
		logic is_space;
		logic is_tab;
		logic is_nl;
		logic is_cr;
		logic is_zero;
		logic is_quote;
		logic is_eq;
		logic is_colon;
	} class_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
		class_t     cls;
	} q_item_t;

	typedef struct packed {
		kind_t                  kind;
		logic [POS_BITS-1:0]    noff;
		logic [POS_BITS-1:0]    nlen;
		logic [POS_BITS-1:0]    voff;
		logic [POS_BITS-1:0]    vlen;
		form_t                  form;
		logic                   attr;
		logic [DEPTH_BITS-1:0]  depth;
	} ev_t;

	function automatic class_t classify(input logic [7:0] c);
		class_t r;
		r.is_name  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		             (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_DOT;
		r.is_space = (c == CH_SPACE);
		r.is_tab   = (c == CH_TAB);
		r.is_nl    = (c == CH_NL);
		r.is_cr    = (c == CH_CR);
		r.is_zero  = (c == CH_ZERO);
		r.is_quote = (c == CH_QUOTE);
		r.is_eq    = (c == CH_EQ);
		r.is_colon = (c == CH_COLON);
		return r;
	endfunction

endpackage

// ----- rtl/imep_front.sv -----
// Front part: accepts text bytes and classifies them for the back part.
// Depends on imep_pkg.
`timescale 1ns / 1ps
module imep_front
	import imep_pkg::*;
(
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	input  logic       final_byte,
	input  logic       q_full,
	output logic       q_push,
	output q_item_t    q_item
);

	assign text_ready = !q_full;
	assign q_push     = text_valid && !q_full;

	always_comb begin
		q_item.text_byte  = text_byte;
		q_item.final_byte = final_byte;
		q_item.cls        = classify(text_byte);
	end

endmodule

// ----- rtl/imep_queue.sv -----
// Short queue of classified bytes between the front and back parts.
// Depends on imep_pkg.
`timescale 1ns / 1ps
module imep_queue
	import imep_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output q_item_t head
);

	q_item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/imep_back.sv -----
// Back part: runs the parser on queued bytes and emits events through an output register.
// Depends on imep_pkg.
`timescale 1ns / 1ps
module imep_back
	import imep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  q_item_t               q_head,
	output logic                  q_pop,
	output logic                  event_valid,
	input  logic                  event_ready,
	output ev_t                   ev_out,
	output logic                  last_out
);

	bk_state_t              st_q, st_d;
	mode_t                  mode_q, mode_d;
	phase_t                 phase_q, phase_d;
	logic [INDENT_BITS-1:0] stack_q [NEST_DEPTH];
	logic [LVL_BITS-1:0]    lvl_q, lvl_d;
	logic [INDENT_BITS-1:0] li_q, li_d;
	logic [POS_BITS-1:0]    pos_q, pos_d, nst_q, nst_d, nlen_q, nlen_d, vst_q, vst_d;
	logic                   halted_q, halted_d;
	class_t                 cls_q;
	logic                   final_q, eof_q, eof_d, cons_q, cons_d;
	logic [CNT_BITS-1:0]    cnt_q, cnt_d;
	logic                   pend_v_q, pend_v_d;
	ev_t                    pend_q;
	logic                   out_v_q;
	ev_t                    out_q;
	logic                   out_last_q;

	logic                   emit, stk_we, f_halt, f_attr, f_pop, f_close, f_cons;
	logic                   f_fin, f_resume, f_eof_done, f_load;
	logic [LVL_BITS-1:0]    stk_wi;
	logic [INDENT_BITS-1:0] stk_wd;
	ev_t                    ev;
	logic                   emit_ok, need_push, can_push, go;

	class_t                 cur;
	logic [POS_BITS-1:0]    p, len_v, node_vlen, nst_v;
	logic                   node_req, sd_req, halt_req;
	form_t                  node_form;
	kind_t                  halt_kind;
	logic [INDENT_BITS-1:0] top_v;
	logic [DEPTH_BITS-1:0]  dep1;

	assign cur   = eof_q ? classify(CH_ZERO) : cls_q;
	assign p     = pos_q;
	assign top_v = stack_q[lvl_q];
	assign dep1  = DEPTH_BITS'(lvl_q) + DEPTH_BITS'(1);

	always_comb begin
		mode_d = mode_q; phase_d = phase_q; lvl_d = lvl_q; li_d = li_q;
		pos_d = pos_q; nst_d = nst_q; nlen_d = nlen_q; vst_d = vst_q;
		halted_d = halted_q; eof_d = eof_q; cons_d = cons_q; cnt_d = cnt_q;
		emit = 1'b0; ev = '0; stk_we = 1'b0; stk_wi = '0; stk_wd = li_q;
		f_halt = 1'b0; f_attr = 1'b0; f_pop = 1'b0; f_close = 1'b0; f_cons = 1'b0;
		f_fin = 1'b0; f_resume = 1'b0; f_eof_done = 1'b0; f_load = 1'b0;
		node_req = 1'b0; sd_req = 1'b0; halt_req = 1'b0;
		node_form = VF_NONE; node_vlen = '0; halt_kind = EV_DEEP;
		len_v = nlen_q; nst_v = nst_q;
		unique case (st_q)
			BK_IDLE: begin
				if (!q_empty) begin
					f_load = !halted_q;
					cnt_d  = '0;
					eof_d  = 1'b0;
				end
			end
			BK_RUN: begin
				unique case (phase_q)
					PH_NAME: begin
						if (cur.is_name) f_cons = 1'b1;
						else begin
							len_v  = p - nst_q;
							nlen_d = len_v;
							sd_req = 1'b1;
						end
					end
					PH_EQ: begin
						vst_d = p;
						if (cur.is_quote) begin
							phase_d = PH_QUOTED;
							vst_d   = p + POS_BITS'(1);
							f_cons  = 1'b1;
						end else phase_d = PH_PLAIN;
					end
					PH_QUOTED: begin
						if (cur.is_zero || cur.is_nl) begin
							halt_req = 1'b1; halt_kind = EV_UNESC;
						end else if (cur.is_quote) begin
							node_req = 1'b1; node_form = VF_QUOTED; node_vlen = p - vst_q;
							f_cons = 1'b1;
						end else f_cons = 1'b1;
					end
					PH_PLAIN: begin
						if (cur.is_zero || cur.is_nl || cur.is_space) begin
							node_req = 1'b1; node_form = VF_PLAIN; node_vlen = p - vst_q;
						end else if (cur.is_quote) begin
							halt_req = 1'b1; halt_kind = EV_ILLEGAL;
						end else begin
							if (cur.is_cr) phase_d = PH_PLAIN_CR;
							f_cons = 1'b1;
						end
					end
					PH_PLAIN_CR: begin
						if (cur.is_nl) begin
							node_req = 1'b1; node_form = VF_PLAIN;
							node_vlen = p - POS_BITS'(1) - vst_q;
						end else phase_d = PH_PLAIN;
					end
					PH_COLON: begin
						if (cur.is_zero || cur.is_nl) begin
							node_req = 1'b1; node_form = VF_COLON; node_vlen = p - vst_q;
						end else f_cons = 1'b1;
					end
					PH_IDLE: begin
						if (mode_q == MODE_INDENT) begin
							if (cur.is_space || cur.is_tab) begin
								if (li_q != '1) li_d = li_q + INDENT_BITS'(1);
								f_cons = 1'b1;
							end else if (top_v < li_q) begin
								if (lvl_q == LVL_BITS'(NEST_DEPTH - 1)) begin
									halt_req = 1'b1; halt_kind = EV_DEEP;
								end else begin
									lvl_d  = lvl_q + LVL_BITS'(1);
									stk_we = 1'b1;
									stk_wi = lvl_q + LVL_BITS'(1);
									mode_d = MODE_CHILD;
								end
							end else begin
								emit = 1'b1; ev.kind = EV_END; ev.depth = dep1;
								if (top_v > li_q) f_pop = 1'b1;
								else mode_d = MODE_CHILD;
							end
						end else if (eof_q) begin
							f_close = 1'b1;
						end else if (mode_q == MODE_ATTR && cur.is_space) begin
							f_cons = 1'b1;
						end else if (cur.is_nl) begin
							mode_d = MODE_INDENT;
							li_d   = '0;
							f_cons = 1'b1;
						end else begin
							nst_v = p;
							nst_d = p;
							if (cur.is_name) begin
								phase_d = PH_NAME;
								f_cons  = 1'b1;
							end else begin
								len_v  = '0;
								nlen_d = '0;
								sd_req = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
				if (sd_req) begin
					if (cur.is_eq) begin
						phase_d = PH_EQ; f_cons = 1'b1;
					end else if (cur.is_colon) begin
						phase_d = PH_COLON; vst_d = p + POS_BITS'(1); f_cons = 1'b1;
					end else node_req = 1'b1;
				end
				if (node_req) begin
					emit       = 1'b1;
					ev.noff    = nst_v;
					ev.voff    = (node_form != VF_NONE) ? vst_q : '0;
					ev.vlen    = (node_form != VF_NONE) ? node_vlen : '0;
					ev.form    = node_form;
					ev.attr    = (mode_q == MODE_ATTR);
					ev.depth   = dep1;
					if (len_v == '0) begin
						ev.kind = EV_BADNAME;
						f_halt  = 1'b1;
					end else begin
						ev.kind = EV_NODE;
						ev.nlen = len_v;
						f_attr  = (mode_q == MODE_ATTR);
						mode_d  = MODE_ATTR;
						phase_d = PH_IDLE;
					end
				end
				if (halt_req) begin
					emit = 1'b1; ev.kind = halt_kind; ev.depth = dep1; f_halt = 1'b1;
				end
				if (f_attr) cons_d = f_cons;
				f_fin = f_cons && !f_attr && !f_halt;
			end
			BK_ATTR_END: begin
				emit = 1'b1; ev.kind = EV_END; ev.depth = dep1;
				f_fin = cons_q;
			end
			BK_POP: begin
				if (lvl_q != '0 && top_v > li_q) begin
					emit = 1'b1; ev.kind = EV_END; ev.depth = DEPTH_BITS'(lvl_q);
					lvl_d = lvl_q - LVL_BITS'(1);
				end else if (top_v != li_q) begin
					emit = 1'b1; ev.kind = EV_INDENT; ev.depth = dep1; f_halt = 1'b1;
				end else begin
					mode_d = MODE_CHILD; f_resume = 1'b1;
				end
			end
			BK_CLOSE: begin
				emit = 1'b1; ev.kind = EV_END; ev.depth = DEPTH_BITS'(lvl_q);
				if (lvl_q == '0) f_eof_done = 1'b1;
				else lvl_d = lvl_q - LVL_BITS'(1);
			end
			BK_EOF: begin
				emit = 1'b1; ev.kind = EV_EOF; lvl_d = '0; f_halt = 1'b1;
			end
			BK_FLUSH: begin
			end
			default: begin
			end
		endcase
		if (f_halt) begin
			halted_d = 1'b1; mode_d = MODE_DONE; phase_d = PH_IDLE;
		end
		if (f_fin) begin
			pos_d = pos_q + POS_BITS'(1);
			if (final_q && !eof_q) eof_d = 1'b1;
		end
		if (emit_ok) cnt_d = cnt_q + CNT_BITS'(1);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE:     if (f_load) st_d = BK_RUN;
			BK_RUN: begin
				priority if (f_halt)  st_d = BK_FLUSH;
				else if (f_attr)      st_d = BK_ATTR_END;
				else if (f_pop)       st_d = BK_POP;
				else if (f_close)     st_d = BK_CLOSE;
				else if (f_fin)       st_d = (final_q && !eof_q) ? BK_RUN : BK_FLUSH;
				else                  st_d = BK_RUN;
			end
			BK_ATTR_END: begin
				if (f_fin) st_d = (final_q && !eof_q) ? BK_RUN : BK_FLUSH;
				else st_d = BK_RUN;
			end
			BK_POP: begin
				if (f_halt) st_d = BK_FLUSH;
				else if (f_resume) st_d = BK_RUN;
			end
			BK_CLOSE:    if (f_eof_done) st_d = BK_EOF;
			BK_EOF:      st_d = BK_FLUSH;
			BK_FLUSH:    st_d = BK_IDLE;
			default:     st_d = BK_IDLE;
		endcase
	end

	assign emit_ok   = emit && (cnt_q < CNT_BITS'(EV_CAP));
	assign can_push  = !out_v_q || event_ready;
	assign need_push = pend_v_q && (emit_ok || st_q == BK_FLUSH);
	assign go        = !need_push || can_push;
	assign q_pop     = (st_q == BK_IDLE) && !q_empty;

	always_comb begin
		pend_v_d = pend_v_q;
		if (emit_ok) pend_v_d = 1'b1;
		else if (st_q == BK_FLUSH) pend_v_d = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (f_load) begin
			cls_q   <= q_head.cls;
			final_q <= q_head.final_byte;
		end
		if (go && emit_ok) pend_q <= ev;
		if (go && need_push) begin
			out_q      <= pend_q;
			out_last_q <= (st_q == BK_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			mode_q   <= MODE_CHILD;
			phase_q  <= PH_IDLE;
			lvl_q    <= '0;
			li_q     <= '0;
			pos_q    <= '0;
			nst_q    <= '0;
			nlen_q   <= '0;
			vst_q    <= '0;
			halted_q <= 1'b0;
			eof_q    <= 1'b0;
			cons_q   <= 1'b0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < NEST_DEPTH; i++) stack_q[i] <= '0;
		end else begin
			if (go) begin
				st_q     <= st_d;
				mode_q   <= mode_d;
				phase_q  <= phase_d;
				lvl_q    <= lvl_d;
				li_q     <= li_d;
				pos_q    <= pos_d;
				nst_q    <= nst_d;
				nlen_q   <= nlen_d;
				vst_q    <= vst_d;
				halted_q <= halted_d;
				eof_q    <= eof_d;
				cons_q   <= cons_d;
				cnt_q    <= cnt_d;
				pend_v_q <= pend_v_d;
				if (stk_we) stack_q[stk_wi] <= stk_wd;
			end
			if (go && need_push) out_v_q <= 1'b1;
			else if (event_ready) out_v_q <= 1'b0;
		end
	end

	assign event_valid = out_v_q;
	assign ev_out      = out_q;
	assign last_out    = out_last_q;

endmodule

// ----- rtl/indented_markup_event_parser.sv -----
// Indented markup event parser: input byte channel, event output channel.
// A front stage classifies each transfer, a short queue decouples it from the parser
// back end; when the output does not stall it, the back end emits one event per cycle.
// Channels: text_valid/text_ready carry text_byte and final_byte; event_valid/
// event_ready carry one event per transfer with its name, value and depth fields.
// Path: a byte passes through the queue and the back end's load register; each event
// waits in a pending register and then moves on to the output register.
// Per byte: the back end loads it, runs its parse steps and then flushes; an attribute
// adds a step for its end, and a line that closes many levels, and end of text, add
// one step per end event. The back end takes no new byte until the last is flushed.
// Reset: arst_n clears the parser to the start of text with one level open and
// empties the queue and output register.
// Stall: when event_ready is low the output holds, the back end stops, and the
// queue fills; text_ready drops once it is full.
// After end of text or any error event the block takes further bytes and drops
// them until reset.
`timescale 1ns / 1ps
module indented_markup_event_parser
	import imep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  logic [7:0]            text_byte,
	input  logic                  final_byte,
	output logic                  event_valid,
	input  logic                  event_ready,
	output logic [2:0]            event_kind,
	output logic [POS_BITS-1:0]   name_offset,
	output logic [POS_BITS-1:0]   name_length,
	output logic [POS_BITS-1:0]   value_offset,
	output logic [POS_BITS-1:0]   value_length,
	output logic [1:0]            value_form,
	output logic                  is_attribute,
	output logic [DEPTH_BITS-1:0] nesting_depth,
	output logic                  last_of_run
);

	logic    q_full, q_push, q_pop, q_empty;
	q_item_t q_item, q_head;
	ev_t     ev;

	imep_front u_front (
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	imep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	imep_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.ev_out      (ev),
		.last_out    (last_of_run)
	);

	assign event_kind    = ev.kind;
	assign name_offset   = ev.noff;
	assign name_length   = ev.nlen;
	assign value_offset  = ev.voff;
	assign value_length  = ev.vlen;
	assign value_form    = ev.form;
	assign is_attribute  = ev.attr;
	assign nesting_depth = ev.depth;

endmodule

// ----- verif/tb_indented_markup_event_parser.sv -----
// Self-checking testbench for indented_markup_event_parser: drives generated markup text
// byte by byte, predicts each event in a scoreboard class and checks every output transfer.
// Depends on imep_pkg and the parser RTL only.
`timescale 1ns / 1ps
module tb_indented_markup_event_parser;
	import imep_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		kind_t      kind;
		logic [15:0] noff;
		logic [15:0] nlen;
		logic [15:0] voff;
		logic [15:0] vlen;
		form_t      form;
		logic       attr;
		logic [4:0] depth;
		logic       last;
	} parse_event_t;

	class markup_scoreboard;
		parse_event_t event_q[$];
		parse_event_t run_q[$];
		int errors;
		mode_t  mode;
		phase_t phase;
		bit [7:0]  levels[NEST_DEPTH];
		int        level;
		bit [7:0]  line_ind;
		bit [15:0] pos;
		bit [15:0] name_start;
		bit [15:0] name_len;
		bit [15:0] value_start;
		bit        halted;

		function new();
			errors = 0;
			mode = MODE_CHILD;
			phase = PH_IDLE;
			foreach (levels[i]) levels[i] = 0;
			level = 0;
			line_ind = 0;
			pos = 0;
			name_start = 0;
			name_len = 0;
			value_start = 0;
			halted = 0;
		endfunction

		function int pending();
			return event_q.size();
		endfunction

		function void emit(kind_t k, bit [15:0] no, bit [15:0] nl, bit [15:0] vo,
			bit [15:0] vl, form_t f, bit a, int d);
			parse_event_t e;
			if (run_q.size() >= EV_CAP)
				return;
			e.kind = k; e.noff = no; e.nlen = nl; e.voff = vo; e.vlen = vl;
			e.form = f; e.attr = a; e.depth = d[4:0]; e.last = 0;
			run_q.push_back(e);
		endfunction

		function void stop_parse();
			halted = 1;
			mode = MODE_DONE;
			phase = PH_IDLE;
		endfunction

		function void halt_with(kind_t k);
			emit(k, 0, 0, 0, 0, VF_NONE, 0, level + 1);
			stop_parse();
		endfunction

		function void close_all();
			for (int k = level; k >= 0; k--)
				emit(EV_END, 0, 0, 0, 0, VF_NONE, 0, k);
			emit(EV_EOF, 0, 0, 0, 0, VF_NONE, 0, 0);
			level = 0;
			stop_parse();
		endfunction

		function bit name_char(bit [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
				(c >= "0" && c <= "9") || c == CH_DASH || c == CH_DOT;
		endfunction

		function void emit_node(form_t f, bit [15:0] vlen);
			bit a;
			bit [15:0] vo;
			bit [15:0] vl;
			a = (mode == MODE_ATTR);
			vo = (f != VF_NONE) ? value_start : 16'd0;
			vl = (f != VF_NONE) ? vlen : 16'd0;
			if (name_len == 0) begin
				emit(EV_BADNAME, name_start, 0, vo, vl, f, a, level + 1);
				stop_parse();
				return;
			end
			emit(EV_NODE, name_start, name_len, vo, vl, f, a, level + 1);
			if (a)
				emit(EV_END, 0, 0, 0, 0, VF_NONE, 0, level + 1);
			mode = MODE_ATTR;
			phase = PH_IDLE;
		endfunction

		function void start_data(bit [7:0] c, inout bit taken);
			if (c == CH_EQ) begin
				phase = PH_EQ;
				taken = 1;
			end else if (c == CH_COLON) begin
				phase = PH_COLON;
				value_start = pos + 16'd1;
				taken = 1;
			end else begin
				emit_node(VF_NONE, 0);
			end
		endfunction

		function void resolve_indent();
			int idx;
			idx = level;
			if (levels[idx] < line_ind) begin
				if (idx + 1 >= NEST_DEPTH) begin
					halt_with(EV_DEEP);
					return;
				end
				level = idx + 1;
				levels[idx + 1] = line_ind;
			end else if (levels[idx] > line_ind) begin
				emit(EV_END, 0, 0, 0, 0, VF_NONE, 0, idx + 1);
				while (idx > 0 && levels[idx] > line_ind) begin
					idx--;
					level = idx;
					emit(EV_END, 0, 0, 0, 0, VF_NONE, 0, idx + 1);
				end
				if (levels[idx] != line_ind) begin
					halt_with(EV_INDENT);
					return;
				end
			end else begin
				emit(EV_END, 0, 0, 0, 0, VF_NONE, 0, idx + 1);
			end
			mode = MODE_CHILD;
		endfunction

		function void parse_byte(bit [7:0] c, bit at_end);
			bit [15:0] p;
			bit taken;
			p = pos;
			taken = 0;
			for (int g = 0; g < 16 && !taken && !halted; g++) begin
				case (phase)
					PH_NAME: begin
						if (name_char(c)) taken = 1;
						else begin
							name_len = p - name_start;
							start_data(c, taken);
						end
					end
					PH_EQ: begin
						value_start = p;
						if (c == CH_QUOTE) begin
							phase = PH_QUOTED;
							value_start = p + 16'd1;
							taken = 1;
						end else phase = PH_PLAIN;
					end
					PH_QUOTED: begin
						if (c == CH_ZERO || c == CH_NL) halt_with(EV_UNESC);
						else if (c == CH_QUOTE) begin
							emit_node(VF_QUOTED, p - value_start);
							taken = 1;
						end else taken = 1;
					end
					PH_PLAIN: begin
						if (c == CH_ZERO || c == CH_NL || c == CH_SPACE)
							emit_node(VF_PLAIN, p - value_start);
						else if (c == CH_QUOTE) halt_with(EV_ILLEGAL);
						else begin
							if (c == CH_CR) phase = PH_PLAIN_CR;
							taken = 1;
						end
					end
					PH_PLAIN_CR: begin
						if (c == CH_NL) emit_node(VF_PLAIN, p - 16'd1 - value_start);
						else phase = PH_PLAIN;
					end
					PH_COLON: begin
						if (c == CH_ZERO || c == CH_NL) emit_node(VF_COLON, p - value_start);
						else taken = 1;
					end
					default: begin
						if (mode == MODE_INDENT) begin
							if (c == CH_SPACE || c == CH_TAB) begin
								if (line_ind != 8'hFF) line_ind++;
								taken = 1;
							end else resolve_indent();
						end else if (at_end) begin
							close_all();
						end else if (mode == MODE_ATTR && c == CH_SPACE) begin
							taken = 1;
						end else if (c == CH_NL) begin
							mode = MODE_INDENT;
							line_ind = 0;
							taken = 1;
						end else begin
							name_start = p;
							if (name_char(c)) begin
								phase = PH_NAME;
								taken = 1;
							end else begin
								name_len = 0;
								start_data(c, taken);
							end
						end
					end
				endcase
			end
		endfunction

		function void note_byte(bit [7:0] c, bit fin);
			run_q.delete();
			if (halted)
				return;
			parse_byte(c, 0);
			pos++;
			if (fin && !halted)
				parse_byte(CH_ZERO, 1);
			if (run_q.size() > 0)
				run_q[run_q.size() - 1].last = 1;
			foreach (run_q[i]) event_q.push_back(run_q[i]);
		endfunction

		function void cmp(string f, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, f, e, a);
				errors++;
			end
		endfunction

		function void check_event(parse_event_t a);
			parse_event_t e;
			if (event_q.size() == 0) begin
				$display("%0t: unexpected event, kind %0d", $time, a.kind);
				errors++;
				return;
			end
			e = event_q.pop_front();
			cmp("event_kind", 16'(e.kind), 16'(a.kind));
			cmp("name_offset", e.noff, a.noff);
			cmp("name_length", e.nlen, a.nlen);
			cmp("value_offset", e.voff, a.voff);
			cmp("value_length", e.vlen, a.vlen);
			cmp("value_form", 16'(e.form), 16'(a.form));
			cmp("is_attribute", 16'(e.attr), 16'(a.attr));
			cmp("nesting_depth", 16'(e.depth), 16'(a.depth));
			cmp("last_of_run", 16'(e.last), 16'(a.last));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic text_valid;
	logic text_ready;
	logic [7:0] text_byte;
	logic final_byte;
	logic event_valid;
	logic event_ready;
	logic [2:0] event_kind;
	logic [POS_BITS-1:0] name_offset;
	logic [POS_BITS-1:0] name_length;
	logic [POS_BITS-1:0] value_offset;
	logic [POS_BITS-1:0] value_length;
	logic [1:0] value_form;
	logic is_attribute;
	logic [DEPTH_BITS-1:0] nesting_depth;
	logic last_of_run;

	markup_scoreboard sb = new();
	bit [8:0] text_q[$];
	int indent_q[$];
	bit hold_req;
	int idle_cycles;

	indented_markup_event_parser u_top (
		.clk(clk), .arst_n(arst_n),
		.text_valid(text_valid), .text_ready(text_ready),
		.text_byte(text_byte), .final_byte(final_byte),
		.event_valid(event_valid), .event_ready(event_ready),
		.event_kind(event_kind), .name_offset(name_offset), .name_length(name_length),
		.value_offset(value_offset), .value_length(value_length),
		.value_form(value_form), .is_attribute(is_attribute),
		.nesting_depth(nesting_depth), .last_of_run(last_of_run)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		parse_event_t got;
		bit moved;
		if (arst_n) begin
			moved = 0;
			if (text_valid && text_ready) begin
				sb.note_byte(text_byte, final_byte);
				moved = 1;
			end
			if (event_valid && event_ready) begin
				got.kind = kind_t'(event_kind);
				got.noff = name_offset; got.nlen = name_length;
				got.voff = value_offset; got.vlen = value_length;
				got.form = form_t'(value_form); got.attr = is_attribute;
				got.depth = nesting_depth; got.last = last_of_run;
				sb.check_event(got);
				moved = 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("indented_markup_event_parser test failed");
				$finish;
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// receiver: rotating stall pattern, plus one long hold on request
	initial begin
		int cyc;
		cyc = 0;
		event_ready = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				event_ready = 0;
				hold_req = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			case ((cyc / 50) % 4)
				0: event_ready = 1;
				1: event_ready = 1'($urandom % 2);
				2: event_ready = ($urandom % 5) != 0;
				default: event_ready = (cyc % 7) >= 3;
			endcase
		end
	end

	function void push_byte(bit [7:0] b);
		text_q.push_back({1'b0, b});
	endfunction

	function void push_str(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	function bit [7:0] name_byte();
		int r;
		r = $urandom % 64;
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r < 62) return 8'("0" + r - 52);
		return (r == 62) ? CH_DASH : CH_DOT;
	endfunction

	// one node with random name and optional value; returns the value form used
	function form_t push_node(bit allow_colon);
		form_t f;
		bit [7:0] b;
		int n;
		n = $urandom_range(1, 8);
		repeat (n) push_byte(name_byte());
		f = form_t'($urandom % 4);
		if (f == VF_COLON && !allow_colon) f = VF_NONE;
		n = $urandom_range(0, 6);
		case (f)
			VF_QUOTED: begin
				push_byte(CH_EQ);
				push_byte(CH_QUOTE);
				repeat (n) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_NL);
					push_byte(b);
				end
				push_byte(CH_QUOTE);
			end
			VF_PLAIN: begin
				push_byte(CH_EQ);
				repeat (n) begin
					do b = 8'($urandom_range(1, 255));
					while (b == CH_QUOTE || b == CH_NL || b == CH_SPACE);
					push_byte(b);
				end
			end
			VF_COLON: begin
				push_byte(CH_COLON);
				repeat (n) begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
					push_byte(b);
				end
			end
			default: ;
		endcase
		return f;
	endfunction

	function void push_line(int ind);
		form_t f;
		int attrs;
		repeat (ind) push_byte(($urandom % 3 == 0) ? CH_TAB : CH_SPACE);
		while (ind < indent_q[$]) void'(indent_q.pop_back());
		if (ind > indent_q[$]) indent_q.push_back(ind);
		attrs = $urandom_range(0, 2);
		f = push_node(attrs == 0);
		for (int i = 0; i < attrs; i++) begin
			repeat ($urandom_range(1, 2)) push_byte(CH_SPACE);
			f = push_node(i == attrs - 1);
		end
		if (f == VF_PLAIN && $urandom % 3 == 0) push_byte(CH_CR);
		push_byte(CH_NL);
	endfunction

	function void push_blank();
		push_byte(CH_NL);
		indent_q = '{0};
	endfunction

	function void build_text();
		int r;
		indent_q = '{0};
		// all name byte kinds, high value bytes, trailing CR, attribute
		push_str("Az09.-=");
		push_byte(CH_QUOTE);
		push_byte(8'hFF);
		push_byte(8'h80);
		push_byte(CH_QUOTE);
		push_str(" k=v");
		push_byte(CH_CR);
		push_byte(CH_NL);
		push_byte(CH_TAB);
		indent_q.push_back(1);
		push_str("n:col :x");
		push_byte(CH_NL);
		push_blank();
		push_str("p q=");
		push_byte(CH_NL);
		// dive to the deepest level
		for (int k = 1; k < NEST_DEPTH; k++) push_line(k);
		push_line(0);
		while (text_q.size() < 400) begin
			r = $urandom % 10;
			if (r == 0) push_blank();
			else if (r < 4 && indent_q.size() < NEST_DEPTH && indent_q[$] < 240)
				push_line(indent_q[$] + $urandom_range(1, 3));
			else if (r < 7 || indent_q.size() == 1) push_line(indent_q[$]);
			else push_line(indent_q[$urandom % (indent_q.size() - 1)]);
		end
		case ($urandom % 6)
			1: begin
				repeat (indent_q[$]) push_byte(CH_SPACE);
				push_str("=x");
				push_byte(CH_NL);
			end
			2: begin
				push_str("a=");
				push_byte(CH_QUOTE);
				push_str("xy");
				push_byte(CH_NL);
			end
			3: begin
				push_str("a=b");
				push_byte(CH_QUOTE);
			end
			4: begin
				r = indent_q[$];
				push_line(r + 3);
				push_line(r + 1);
			end
			5: repeat (NEST_DEPTH + 1) push_line(indent_q[$] + 1);
			default: if ($urandom % 2) void'(text_q.pop_back());
		endcase
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
		text_q[text_q.size() - 1][8] = 1'b1;
	endfunction

	task automatic send_byte(bit [8:0] item);
		@(negedge clk);
		text_valid = 1;
		text_byte = item[7:0];
		final_byte = item[8];
		do @(posedge clk); while (!text_ready);
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		text_valid = 0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	initial begin
		int burst;
		arst_n = 0;
		text_valid = 0;
		text_byte = 0;
		final_byte = 0;
		hold_req = 0;
		idle_cycles = 0;
		build_text();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		burst = $urandom_range(1, 30);
		foreach (text_q[k]) begin
			if (k == 150) hold_req = 1;
			if (k == 300) begin
				pause_sender(1);
				while (sb.pending() != 0) @(posedge clk);
			end
			if (burst == 0) begin
				pause_sender($urandom_range(1, 6));
				burst = ($urandom % 4 == 0) ? 200 : $urandom_range(1, 30);
			end
			send_byte(text_q[k]);
			burst--;
		end
		@(negedge clk);
		text_valid = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("indented_markup_event_parser test passed");
		else
			$display("indented_markup_event_parser test failed");
		$finish;
	end

endmodule
